>>> rtl/frt_pkg.sv
// frt_pkg: constants, operation codes, entry and control types shared by the
// frame range table modules. No dependencies.
package frt_pkg;

   localparam int MAX_RANGES = 64;
   localparam int FRAME_BITS = 24;
   localparam int IDX_W      = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);
   localparam int RCNT_W     = 7;
   localparam int OP_W       = 3;
   localparam int ENT_W      = 2 * FRAME_BITS + 1;
   localparam int IN_W       = 56;
   localparam int OUT_W      = 64;
   localparam int OUT_PAD    = OUT_W - (2 * FRAME_BITS + 3 + RCNT_W);

   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_W-1:0] OP_MERGE   = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd4;
   localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;

   typedef struct packed {
      logic [FRAME_BITS-1:0] start;
      logic [FRAME_BITS-1:0] len;
      logic                  masked;
   } entry_type;

   typedef struct packed {
      logic      ins;
      logic      a_vld;
      entry_type a;
      logic      b_vld;
      entry_type b;
      entry_type pend;
      logic      done;
   } edit_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PROC,
      S_EXTRA,
      S_TAIL,
      S_DONE
   } state_type;

endpackage

>>> rtl/frame_range_table_core.sv
// frame_range_table_core: ordered table of source-frame ranges with append,
// merge add, delete span, lookup, reverse lookup and clear. Depends on frt_pkg,
// frt_ram and frt_edit.
//
// One item is worked at a time. The table lives in two banks of 64-entry RAM:
// an edit streams the current bank through frt_edit into the spare bank and
// swaps banks when it succeeds, so a refused insert leaves the table as it was.
// Each stored range is read from RAM (S_READ) and then processed (S_PROC), an
// entry that splits takes an extra write state (S_EXTRA), and accept, commit
// (S_TAIL) and result (S_DONE) are steps of their own. Lookups stop at the hit.
// The next item is taken while the previous result waits on the rsp side.
module frame_range_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // frame, range_len, masked_in, zero pad
   input  logic [frt_pkg::IN_W-1:0]       req_tdata,
   // operation
   input  logic [frt_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_frame, run_length, found, masked_out, table_full, range_count, zero pad
   output logic [frt_pkg::OUT_W-1:0]      rsp_tdata
);
   import frt_pkg::*;

   localparam int FB = FRAME_BITS;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   entry_type             pend_ff, pend_in;
   logic                  done_ff, done_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      wcnt_ff, wcnt_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  bank_ff, bank_in;
   entry_type             hold_ff, hold_in;
   logic [FB-1:0]         f_ff, f_in;
   logic [FB:0]           acc_ff, acc_in;
   logic                  um_vld_ff, um_vld_in;
   logic [FB-1:0]         um_val_ff, um_val_in;
   logic [FB-1:0]         first_s_ff, first_s_in;
   logic [FB-1:0]         rf_ff, rf_in;
   logic [FB-1:0]         rl_ff, rl_in;
   logic                  fnd_ff, fnd_in;
   logic                  mo_ff, mo_in;
   logic                  full_ff, full_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [OUT_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  wen;
   entry_type             wdata;
   logic [ENT_W-1:0]      rd0, rd1;
   entry_type             ent;
   edit_type              ed;

   logic                  accept;
   logic                  is_mod;
   logic                  room_ok;
   logic                  ins_fail;
   logic                  lk_hit;
   logic                  rv_hit;
   logic                  tail_need;
   logic                  tail_fail;
   logic                  last;
   logic [FB:0]           ent_end;
   logic [FB:0]           rv_sum;
   logic [FB:0]           acc_sum;
   logic [CNT_W:0]        live_cnt;
   logic [FB-1:0]         in_frame;
   logic [FB-1:0]         in_len;

   frt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_RANGES)) u_ram0 (
      .clock (clock),
      .we    (wen & bank_ff),
      .waddr (wcnt_ff[IDX_W-1:0]),
      .wdata (wdata),
      .raddr (idx_ff),
      .rdata (rd0)
   );

   frt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_RANGES)) u_ram1 (
      .clock (clock),
      .we    (wen & ~bank_ff),
      .waddr (wcnt_ff[IDX_W-1:0]),
      .wdata (wdata),
      .raddr (idx_ff),
      .rdata (rd1)
   );

   assign ent = bank_ff ? rd1 : rd0;

   frt_edit u_edit (
      .op   (op_ff),
      .pend (pend_ff),
      .done (done_ff),
      .ent  (ent),
      .res  (ed)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign in_frame   = req_tdata[FB-1:0];
   assign in_len     = req_tdata[2*FB-1:FB];

   assign is_mod    = (op_ff == OP_APPEND) || (op_ff == OP_MERGE) || (op_ff == OP_DELETE);
   assign live_cnt  = {1'b0, wcnt_ff} + {1'b0, cnt_ff} - (CNT_W+1)'(idx_ff);
   assign room_ok   = live_cnt < (CNT_W+1)'(MAX_RANGES);
   assign ins_fail  = is_mod && ed.ins && !room_ok;
   assign ent_end   = {1'b0, ent.start} + {1'b0, ent.len};
   assign lk_hit    = (op_ff == OP_LOOKUP) && (f_ff < ent.len);
   assign rv_hit    = (op_ff == OP_REVERSE) && (pend_ff.start >= ent.start)
                      && ({1'b0, pend_ff.start} < ent_end);
   assign tail_need = is_mod && (op_ff != OP_DELETE) && !done_ff;
   assign tail_fail = tail_need && (wcnt_ff >= CNT_W'(MAX_RANGES));
   assign last      = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;
   assign rv_sum    = acc_ff + {1'b0, pend_ff.start - ent.start};
   assign acc_sum   = acc_ff + {1'b0, ent.len};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((req_tuser != OP_CLEAR) && (req_tuser <= OP_REVERSE)
                   && (cnt_ff != '0)) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_TAIL;
               end
            end
         end
         S_READ: state_in = S_PROC;
         S_PROC: begin
            if (ins_fail || lk_hit || rv_hit) begin
               state_in = S_DONE;
            end else if (is_mod && ed.b_vld) begin
               state_in = S_EXTRA;
            end else begin
               state_in = last ? S_TAIL : S_READ;
            end
         end
         S_EXTRA: state_in = last ? S_TAIL : S_READ;
         S_TAIL:  state_in = S_DONE;
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in       = op_ff;
      pend_in     = pend_ff;
      done_in     = done_ff;
      idx_in      = idx_ff;
      wcnt_in     = wcnt_ff;
      cnt_in      = cnt_ff;
      bank_in     = bank_ff;
      hold_in     = hold_ff;
      f_in        = f_ff;
      acc_in      = acc_ff;
      um_vld_in   = um_vld_ff;
      um_val_in   = um_val_ff;
      first_s_in  = first_s_ff;
      rf_in       = rf_ff;
      rl_in       = rl_ff;
      fnd_in      = fnd_ff;
      mo_in       = mo_ff;
      full_in     = full_ff;
      rsp_vld_in  = rsp_vld_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      wen         = 1'b0;
      wdata       = ed.a;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in          = req_tuser;
               pend_in.start  = in_frame;
               pend_in.len    = in_len;
               pend_in.masked = req_tdata[2*FB];
               if (((req_tuser == OP_APPEND) || (req_tuser == OP_MERGE))
                   && (in_len > ~in_frame)) begin
                  pend_in.len = ~in_frame;
               end
               done_in   = 1'b0;
               idx_in    = '0;
               wcnt_in   = '0;
               f_in      = in_frame;
               acc_in    = '0;
               um_vld_in = 1'b0;
               rf_in     = '0;
               rl_in     = '0;
               fnd_in    = 1'b0;
               mo_in     = 1'b0;
               full_in   = 1'b0;
            end
         end
         S_READ: begin
         end
         S_PROC: begin
            if (is_mod) begin
               if (ins_fail) begin
                  full_in = 1'b1;
               end else begin
                  if (ed.a_vld) begin
                     wen     = 1'b1;
                     wcnt_in = wcnt_ff + CNT_W'(1);
                  end
                  hold_in = ed.b;
                  pend_in = ed.pend;
                  done_in = ed.done;
                  if (!ed.b_vld) begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end else if (op_ff == OP_LOOKUP) begin
               if (idx_ff == '0) begin
                  first_s_in = ent.start;
               end
               if (lk_hit) begin
                  fnd_in = 1'b1;
                  mo_in  = ent.masked;
                  if (ent.masked) begin
                     rl_in = FB'(1);
                     if (um_vld_ff) begin
                        rf_in = um_val_ff;
                     end else begin
                        rf_in = (idx_ff == '0) ? ent.start : first_s_ff;
                     end
                  end else begin
                     rl_in = ent.len - f_ff;
                     rf_in = ent.start + f_ff;
                  end
               end else begin
                  f_in = f_ff - ent.len;
                  if (!ent.masked) begin
                     um_vld_in = 1'b1;
                     um_val_in = (ent.len == '0) ? ent.start
                                 : (ent.start + ent.len - FB'(1));
                  end
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               if (rv_hit) begin
                  fnd_in = 1'b1;
                  mo_in  = ent.masked;
                  rf_in  = rv_sum[FB] ? {FB{1'b1}} : rv_sum[FB-1:0];
               end else begin
                  acc_in = acc_sum[FB] ? {1'b1, {FB{1'b0}}} : acc_sum;
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_EXTRA: begin
            wen     = 1'b1;
            wdata   = hold_ff;
            wcnt_in = wcnt_ff + CNT_W'(1);
            idx_in  = idx_ff + IDX_W'(1);
         end
         S_TAIL: begin
            if (op_ff == OP_CLEAR) begin
               cnt_in = '0;
            end else if (is_mod) begin
               if (tail_fail) begin
                  full_in = 1'b1;
               end else begin
                  if (tail_need) begin
                     wen   = 1'b1;
                     wdata = pend_ff;
                  end
                  bank_in = ~bank_ff;
                  cnt_in  = wcnt_ff + (tail_need ? CNT_W'(1) : CNT_W'(0));
               end
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {{OUT_PAD{1'b0}}, RCNT_W'(cnt_ff), full_ff, mo_ff, fnd_ff,
                              rl_ff, rf_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         bank_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         bank_ff    <= bank_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pend_ff     <= pend_in;
      done_ff     <= done_in;
      idx_ff      <= idx_in;
      wcnt_ff     <= wcnt_in;
      hold_ff     <= hold_in;
      f_ff        <= f_in;
      acc_ff      <= acc_in;
      um_vld_ff   <= um_vld_in;
      um_val_ff   <= um_val_in;
      first_s_ff  <= first_s_in;
      rf_ff       <= rf_in;
      rl_ff       <= rl_in;
      fnd_ff      <= fnd_in;
      mo_ff       <= mo_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RANGES))
      else $error("range count above table size");

   a_proc_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROC) |-> ($past(state_ff) == S_READ))
      else $error("entry processed without a read");

   a_bank_on_commit: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> ($past(state_ff) == S_TAIL))
      else $error("bank swapped outside commit");
`endif

endmodule

>>> rtl/frt_ram.sv
// frt_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module frt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/frt_edit.sv
// frt_edit: per-entry edit step for merge add, delete span and append while
// the table is streamed into the spare bank. Depends on frt_pkg.
module frt_edit (
   input  logic [frt_pkg::OP_W-1:0] op,
   input  frt_pkg::entry_type       pend,
   input  logic                     done,
   input  frt_pkg::entry_type       ent,
   output frt_pkg::edit_type        res
);
   import frt_pkg::*;

   logic [FRAME_BITS:0]   pe;
   logic [FRAME_BITS:0]   ie;
   logic [FRAME_BITS-1:0] lo_start;

   assign pe = {1'b0, pend.start} + {1'b0, pend.len};
   assign ie = {1'b0, ent.start} + {1'b0, ent.len};
   assign lo_start = (ent.start < pend.start) ? ent.start : pend.start;

   always_comb begin
      res.ins   = 1'b0;
      res.a_vld = 1'b1;
      res.a     = ent;
      res.b_vld = 1'b0;
      res.b     = ent;
      res.pend  = pend;
      res.done  = done;
      if (!done) begin
         case (op)
            OP_MERGE: begin
               if (pe < {1'b0, ent.start}) begin
                  res.ins   = 1'b1;
                  res.a     = pend;
                  res.b_vld = 1'b1;
                  res.done  = 1'b1;
               end else if ({1'b0, pend.start} <= ie) begin
                  if (pe > ie) begin
                     if (pend.masked != ent.masked) begin
                        if (pend.start < ent.start) begin
                           res.ins      = 1'b1;
                           res.a.start  = pend.start;
                           res.a.len    = ent.start - pend.start;
                           res.a.masked = pend.masked;
                           res.b_vld    = 1'b1;
                        end
                        res.pend.start = ie[FRAME_BITS-1:0];
                        res.pend.len   = FRAME_BITS'(pe - ie);
                     end else begin
                        res.a_vld      = 1'b0;
                        res.pend.start = lo_start;
                        res.pend.len   = FRAME_BITS'(pe - {1'b0, lo_start});
                     end
                  end else begin
                     res.done = 1'b1;
                     if (ent.start > pend.start) begin
                        if (pend.masked != ent.masked) begin
                           res.ins      = 1'b1;
                           res.a.start  = pend.start;
                           res.a.len    = ent.start - pend.start;
                           res.a.masked = pend.masked;
                           res.b_vld    = 1'b1;
                        end else begin
                           res.a.start = pend.start;
                           res.a.len   = FRAME_BITS'(ie - {1'b0, pend.start});
                        end
                     end
                  end
               end
            end
            OP_DELETE: begin
               if ({1'b0, ent.start} >= pe) begin
                  res.done = 1'b1;
               end else if (ie >= {1'b0, pend.start}) begin
                  if (ie > pe) begin
                     res.done = 1'b1;
                     if (ent.start < pend.start) begin
                        res.ins      = 1'b1;
                        res.a.len    = pend.start - ent.start;
                        res.b_vld    = 1'b1;
                        res.b.start  = pe[FRAME_BITS-1:0];
                        res.b.len    = FRAME_BITS'(ie - pe);
                     end else begin
                        res.a.start  = pe[FRAME_BITS-1:0];
                        res.a.len    = FRAME_BITS'(ie - pe);
                     end
                  end else if (ent.start < pend.start) begin
                     res.a.len = pend.start - ent.start;
                  end else begin
                     res.a_vld = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
